[hw/rtl/bsm_pkg.sv]
// Shared types and constants for the bounding sphere merge pipeline.
// Used by the sqrt cell, the divider cell and the top level.
package bsm_pkg;

    localparam int COORD_W = 32;
    localparam int RAD_W   = COORD_W - 1;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int ROOT_W  = DIFF_W;
    localparam int SREM_W  = ROOT_W + 2;
    localparam int QUO_W   = DIFF_W + 1;
    localparam int NUM_W   = 2 * DIFF_W;

    localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

    typedef enum logic [1:0] {
        OUT_FIRST  = 2'd0,
        OUT_SECOND = 2'd1,
        OUT_MERGED = 2'd2
    } bsm_outcome_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  dz;
        logic signed [COORD_W-1:0] c1x;
        logic signed [COORD_W-1:0] c1y;
        logic signed [COORD_W-1:0] c1z;
        logic signed [COORD_W-1:0] c2x;
        logic signed [COORD_W-1:0] c2y;
        logic signed [COORD_W-1:0] c2z;
        logic [RAD_W-1:0]          r1;
        logic [RAD_W-1:0]          r2;
    } bsm_geo_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [RAD_W-1:0]          radius;
        bsm_outcome_t              outcome;
    } bsm_res_t;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [QUO_W-1:0]  num;
        logic [QUO_W-1:0]  quo;
        logic              sat;
        logic              neg;
    } bsm_lane_t;

endpackage

[hw/rtl/bsm_sqrt_cell.sv]
// One digit cell of the pipelined integer square root: one root bit per cell.
// Carries the sphere geometry alongside. Depends on bsm_pkg.
module bsm_sqrt_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid_in,
    input  bsm_pkg::bsm_geo_t          geo_in,
    input  logic [bsm_pkg::SQ_W-1:0]   n_in,
    input  logic [bsm_pkg::SREM_W-1:0] rem_in,
    input  logic [bsm_pkg::ROOT_W-1:0] root_in,
    output logic                       valid_out,
    output bsm_pkg::bsm_geo_t          geo_out,
    output logic [bsm_pkg::SQ_W-1:0]   n_out,
    output logic [bsm_pkg::SREM_W-1:0] rem_out,
    output logic [bsm_pkg::ROOT_W-1:0] root_out
);
    import bsm_pkg::*;

    logic [SREM_W+1:0] rem_sh;
    logic [SREM_W+1:0] trial;
    logic [SREM_W+1:0] diff;
    logic              take;

    always_comb
    begin
        rem_sh = {rem_in, n_in[SQ_W-1 -: 2]};
        trial  = {2'b00, root_in, 2'b01};
        diff   = rem_sh - trial;
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out <= 1'b0;
        end
        else if (en)
        begin
            valid_out <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_out  <= geo_in;
            n_out    <= {n_in[SQ_W-3:0], 2'b00};
            rem_out  <= take ? diff[SREM_W-1:0] : rem_sh[SREM_W-1:0];
            root_out <= {root_in[ROOT_W-2:0], take};
        end
    end

endmodule

[hw/rtl/bsm_div_cell.sv]
// One digit cell of the pipelined restoring divider: one quotient bit per
// cell for each of the three axis lanes. Depends on bsm_pkg.
module bsm_div_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_in,
    input  bsm_pkg::bsm_res_t             res_in,
    input  logic [bsm_pkg::ROOT_W-1:0]    len_in,
    input  bsm_pkg::bsm_lane_t [2:0]      lanes_in,
    output logic                          valid_out,
    output bsm_pkg::bsm_res_t             res_out,
    output logic [bsm_pkg::ROOT_W-1:0]    len_out,
    output bsm_pkg::bsm_lane_t [2:0]      lanes_out
);
    import bsm_pkg::*;

    bsm_lane_t [2:0] lanes_next;
    logic [ROOT_W:0] rem_sh [3];
    logic [ROOT_W:0] diff [3];
    logic            take [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_sh[i] = {lanes_in[i].rem, lanes_in[i].num[QUO_W-1]};
            diff[i]   = rem_sh[i] - {1'b0, len_in};
            take[i]   = (rem_sh[i] >= {1'b0, len_in});
            lanes_next[i].rem = take[i] ? diff[i][ROOT_W-1:0] : rem_sh[i][ROOT_W-1:0];
            lanes_next[i].num = {lanes_in[i].num[QUO_W-2:0], 1'b0};
            lanes_next[i].quo = {lanes_in[i].quo[QUO_W-2:0], take[i]};
            lanes_next[i].sat = lanes_in[i].sat;
            lanes_next[i].neg = lanes_in[i].neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out <= 1'b0;
        end
        else if (en)
        begin
            valid_out <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_out   <= res_in;
            len_out   <= len_in;
            lanes_out <= lanes_next;
        end
    end

endmodule

[hw/rtl/bounding_sphere_merge.sv]
// Smallest sphere enclosing two spheres, fully pipelined: one beat per cycle while in_stall is low.
// The pipeline holds three front stages, 33 square root cells, two setup stages,
// 34 divider cells and the output register.
// A two-entry output buffer keeps the pipeline moving until the skid entry fills.
// Asynchronous active-low reset clears all valid bits; payload is not reset.
// Depends on bsm_pkg, bsm_sqrt_cell and bsm_div_cell.
module bounding_sphere_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [bsm_pkg::COORD_W-1:0]  first_center_x,
    input  logic signed [bsm_pkg::COORD_W-1:0]  first_center_y,
    input  logic signed [bsm_pkg::COORD_W-1:0]  first_center_z,
    input  logic [bsm_pkg::RAD_W-1:0]           first_radius,
    input  logic signed [bsm_pkg::COORD_W-1:0]  second_center_x,
    input  logic signed [bsm_pkg::COORD_W-1:0]  second_center_y,
    input  logic signed [bsm_pkg::COORD_W-1:0]  second_center_z,
    input  logic [bsm_pkg::RAD_W-1:0]           second_radius,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [bsm_pkg::COORD_W-1:0]  merged_center_x,
    output logic signed [bsm_pkg::COORD_W-1:0]  merged_center_y,
    output logic signed [bsm_pkg::COORD_W-1:0]  merged_center_z,
    output logic [bsm_pkg::RAD_W-1:0]           merged_radius,
    output logic [1:0]                          outcome
);
    import bsm_pkg::*;

    localparam int SQ_CELLS  = ROOT_W;
    localparam int DIV_CELLS = QUO_W;
    localparam int VW        = COORD_W + 5;

    logic en;
    logic skid_full_reg;

    // Front stages.
    logic            s0_valid_reg;
    bsm_geo_t        s0_geo_reg;
    logic            s1_valid_reg;
    bsm_geo_t        s1_geo_reg;
    logic [SQ_W-1:0] s1_sq_reg [3];
    logic            s2_valid_reg;
    bsm_geo_t        s2_geo_reg;
    logic [SQ_W-1:0] s2_sum_reg;
    logic [DIFF_W-1:0] abs_d0 [3];

    always_comb
    begin
        abs_d0[0] = s0_geo_reg.dx[DIFF_W-1] ? -s0_geo_reg.dx : s0_geo_reg.dx;
        abs_d0[1] = s0_geo_reg.dy[DIFF_W-1] ? -s0_geo_reg.dy : s0_geo_reg.dy;
        abs_d0[2] = s0_geo_reg.dz[DIFF_W-1] ? -s0_geo_reg.dz : s0_geo_reg.dz;
    end

    assign en       = !skid_full_reg;
    assign in_stall = skid_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_geo_reg.c1x <= first_center_x;
            s0_geo_reg.c1y <= first_center_y;
            s0_geo_reg.c1z <= first_center_z;
            s0_geo_reg.c2x <= second_center_x;
            s0_geo_reg.c2y <= second_center_y;
            s0_geo_reg.c2z <= second_center_z;
            s0_geo_reg.r1  <= first_radius;
            s0_geo_reg.r2  <= second_radius;
            s0_geo_reg.dx  <= {second_center_x[COORD_W-1], second_center_x}
                            - {first_center_x[COORD_W-1], first_center_x};
            s0_geo_reg.dy  <= {second_center_y[COORD_W-1], second_center_y}
                            - {first_center_y[COORD_W-1], first_center_y};
            s0_geo_reg.dz  <= {second_center_z[COORD_W-1], second_center_z}
                            - {first_center_z[COORD_W-1], first_center_z};
            s1_geo_reg <= s0_geo_reg;
            for (int i = 0; i < 3; i++)
            begin
                s1_sq_reg[i] <= abs_d0[i] * abs_d0[i];
            end
            s2_geo_reg <= s1_geo_reg;
            s2_sum_reg <= s1_sq_reg[0] + s1_sq_reg[1] + s1_sq_reg[2];
        end
    end

    // Square root chain.
    logic              sq_valid [SQ_CELLS+1];
    bsm_geo_t          sq_geo   [SQ_CELLS+1];
    logic [SQ_W-1:0]   sq_n     [SQ_CELLS+1];
    logic [SREM_W-1:0] sq_rem   [SQ_CELLS+1];
    logic [ROOT_W-1:0] sq_root  [SQ_CELLS+1];

    assign sq_valid[0] = s2_valid_reg;
    assign sq_geo[0]   = s2_geo_reg;
    assign sq_n[0]     = s2_sum_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;

    for (genvar k = 0; k < SQ_CELLS; k++)
    begin : g_sqrt
        bsm_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sq_valid[k]),
            .geo_in    (sq_geo[k]),
            .n_in      (sq_n[k]),
            .rem_in    (sq_rem[k]),
            .root_in   (sq_root[k]),
            .valid_out (sq_valid[k+1]),
            .geo_out   (sq_geo[k+1]),
            .n_out     (sq_n[k+1]),
            .rem_out   (sq_rem[k+1]),
            .root_out  (sq_root[k+1])
        );
    end

    // Containment decision and merged radius.
    bsm_geo_t                 g;
    logic signed [ROOT_W+2:0] len_s;
    logic signed [ROOT_W+2:0] r1_s;
    logic signed [ROOT_W+2:0] r2_s;
    logic signed [ROOT_W+2:0] lo_a;
    logic signed [ROOT_W+2:0] lo_b;
    logic signed [ROOT_W+2:0] lo;
    logic signed [ROOT_W+2:0] top_a;
    logic signed [ROOT_W+2:0] top;
    logic signed [ROOT_W+2:0] span;
    logic signed [ROOT_W+2:0] hi;
    logic signed [ROOT_W+2:0] s_val;
    logic signed [ROOT_W+2:0] s_abs;
    bsm_res_t                 dec_res;

    always_comb
    begin
        g     = sq_geo[SQ_CELLS];
        len_s = $signed({3'b000, sq_root[SQ_CELLS]});
        r1_s  = $signed({{(ROOT_W+3-RAD_W){1'b0}}, g.r1});
        r2_s  = $signed({{(ROOT_W+3-RAD_W){1'b0}}, g.r2});
        lo_a  = -r1_s;
        lo_b  = len_s - r2_s;
        lo    = (lo_b < lo_a) ? lo_b : lo_a;
        top_a = len_s + r2_s;
        top   = (top_a > r1_s) ? top_a : r1_s;
        span  = top - lo;
        hi    = span >>> 1;
        s_val = hi + lo;
        s_abs = s_val[ROOT_W+2] ? -s_val : s_val;
        priority if (r1_s - r2_s >= len_s)
        begin
            dec_res.cx      = g.c1x;
            dec_res.cy      = g.c1y;
            dec_res.cz      = g.c1z;
            dec_res.radius  = g.r1;
            dec_res.outcome = OUT_FIRST;
        end
        else if (r2_s - r1_s >= len_s)
        begin
            dec_res.cx      = g.c2x;
            dec_res.cy      = g.c2y;
            dec_res.cz      = g.c2z;
            dec_res.radius  = g.r2;
            dec_res.outcome = OUT_SECOND;
        end
        else
        begin
            dec_res.cx      = g.c1x;
            dec_res.cy      = g.c1y;
            dec_res.cz      = g.c1z;
            dec_res.radius  = (hi > $signed({{(ROOT_W+3-RAD_W){1'b0}}, RAD_MAX}))
                            ? RAD_MAX : hi[RAD_W-1:0];
            dec_res.outcome = OUT_MERGED;
        end
    end

    logic              s3_valid_reg;
    bsm_res_t          s3_res_reg;
    logic [ROOT_W-1:0] s3_len_reg;
    logic [DIFF_W-1:0] s3_absd_reg [3];
    logic              s3_neg_reg [3];
    logic [DIFF_W-1:0] s3_abss_reg;
    logic              s4_valid_reg;
    bsm_res_t          s4_res_reg;
    logic [ROOT_W-1:0] s4_len_reg;
    logic [NUM_W-1:0]  s4_num_reg [3];
    logic              s4_neg_reg [3];
    logic              d_neg [3];

    always_comb
    begin
        d_neg[0] = g.dx[DIFF_W-1];
        d_neg[1] = g.dy[DIFF_W-1];
        d_neg[2] = g.dz[DIFF_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= sq_valid[SQ_CELLS];
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_res_reg     <= dec_res;
            s3_len_reg     <= sq_root[SQ_CELLS];
            s3_absd_reg[0] <= g.dx[DIFF_W-1] ? -g.dx : g.dx;
            s3_absd_reg[1] <= g.dy[DIFF_W-1] ? -g.dy : g.dy;
            s3_absd_reg[2] <= g.dz[DIFF_W-1] ? -g.dz : g.dz;
            for (int i = 0; i < 3; i++)
            begin
                s3_neg_reg[i] <= d_neg[i] ^ s_val[ROOT_W+2];
            end
            s3_abss_reg <= s_abs[DIFF_W-1:0];
            s4_res_reg  <= s3_res_reg;
            s4_len_reg  <= s3_len_reg;
            for (int i = 0; i < 3; i++)
            begin
                s4_num_reg[i] <= s3_absd_reg[i] * s3_abss_reg;
                s4_neg_reg[i] <= s3_neg_reg[i];
            end
        end
    end

    // Divider chain.
    logic                  dv_valid [DIV_CELLS+1];
    bsm_res_t              dv_res   [DIV_CELLS+1];
    logic [ROOT_W-1:0]     dv_len   [DIV_CELLS+1];
    bsm_lane_t [2:0]       dv_lanes [DIV_CELLS+1];
    logic [NUM_W-QUO_W-1:0] num_top [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_top[i]          = s4_num_reg[i][NUM_W-1:QUO_W];
            dv_lanes[0][i].sat  = ({1'b0, num_top[i]} >= s4_len_reg);
            dv_lanes[0][i].rem  = {1'b0, num_top[i]};
            dv_lanes[0][i].num  = s4_num_reg[i][QUO_W-1:0];
            dv_lanes[0][i].quo  = '0;
            dv_lanes[0][i].neg  = s4_neg_reg[i];
        end
    end

    assign dv_valid[0] = s4_valid_reg;
    assign dv_res[0]   = s4_res_reg;
    assign dv_len[0]   = s4_len_reg;

    for (genvar k = 0; k < DIV_CELLS; k++)
    begin : g_div
        bsm_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv_valid[k]),
            .res_in    (dv_res[k]),
            .len_in    (dv_len[k]),
            .lanes_in  (dv_lanes[k]),
            .valid_out (dv_valid[k+1]),
            .res_out   (dv_res[k+1]),
            .len_out   (dv_len[k+1]),
            .lanes_out (dv_lanes[k+1])
        );
    end

    // Center offset, saturation and result selection.
    localparam logic signed [VW-1:0] V_MAX = VW'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic signed [VW-1:0] V_MIN = -V_MAX - VW'(1);

    bsm_res_t              fin;
    bsm_res_t              last_res;
    bsm_lane_t [2:0]       last_lanes;
    logic [COORD_W-1:0]    base [3];
    logic signed [VW-1:0]  v [3];
    logic signed [VW-1:0]  vc [3];
    logic signed [VW-1:0]  base_e;
    logic signed [VW-1:0]  q_e;

    always_comb
    begin
        last_res   = dv_res[DIV_CELLS];
        last_lanes = dv_lanes[DIV_CELLS];
        base[0]    = last_res.cx;
        base[1]    = last_res.cy;
        base[2]    = last_res.cz;
        base_e     = '0;
        q_e        = '0;
        for (int i = 0; i < 3; i++)
        begin
            base_e = $signed({{(VW-COORD_W){base[i][COORD_W-1]}}, base[i]});
            q_e    = $signed({{(VW-QUO_W){1'b0}}, last_lanes[i].quo});
            v[i]   = last_lanes[i].neg ? base_e - q_e : base_e + q_e;
            priority if (last_lanes[i].sat)
            begin
                vc[i] = last_lanes[i].neg ? V_MIN : V_MAX;
            end
            else if (v[i] > V_MAX)
            begin
                vc[i] = V_MAX;
            end
            else if (v[i] < V_MIN)
            begin
                vc[i] = V_MIN;
            end
            else
            begin
                vc[i] = v[i];
            end
        end
        fin = last_res;
        if (last_res.outcome == OUT_MERGED)
        begin
            fin.cx = vc[0][COORD_W-1:0];
            fin.cy = vc[1][COORD_W-1:0];
            fin.cz = vc[2][COORD_W-1:0];
        end
    end

    // Output register with one skid entry.
    logic     out_valid_reg;
    bsm_res_t out_reg;
    bsm_res_t skid_reg;
    logic     last_valid;
    logic     out_free;

    assign last_valid = dv_valid[DIV_CELLS] && en;
    assign out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            priority if (last_valid)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_full_reg <= 1'b1;
                end
            end
            else if (out_free)
            begin
                out_valid_reg <= skid_full_reg;
                skid_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (last_valid)
        begin
            if (out_free)
            begin
                out_reg <= fin;
            end
            else
            begin
                skid_reg <= fin;
            end
        end
        else if (out_free && skid_full_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign merged_center_x = out_reg.cx;
    assign merged_center_y = out_reg.cy;
    assign merged_center_z = out_reg.cz;
    assign merged_radius   = out_reg.radius;
    assign outcome         = out_reg.outcome;

endmodule

[hw/rtl/bsm_checker.sv]
// Port-level checks for the bounding sphere merge block, bound to the top level.
// Depends on bsm_pkg and bounding_sphere_merge.
module bsm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [bsm_pkg::COORD_W-1:0] merged_center_x,
    input logic [bsm_pkg::RAD_W-1:0]          merged_radius,
    input logic [1:0]                         outcome
);
    import bsm_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(merged_center_x) && $stable(merged_radius)
            && $stable(outcome))
        else $error("output beat changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without a stalled output");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled while output is empty");

endmodule

bind bounding_sphere_merge bsm_checker u_bsm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .merged_center_x (merged_center_x),
    .merged_radius   (merged_radius),
    .outcome         (outcome)
);

[tb/tb_top.sv]
// Self-checking testbench for bounding_sphere_merge: directed and random sphere pairs.
// Predicts each merged sphere in 128-bit integer arithmetic and checks every result beat.
// Depends on bsm_pkg and the bounding_sphere_merge RTL.
`timescale 1ns / 100ps

module tb_top;
    import bsm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [COORD_W-1:0] first_center_x, first_center_y, first_center_z;
    logic [RAD_W-1:0] first_radius;
    logic signed [COORD_W-1:0] second_center_x, second_center_y, second_center_z;
    logic [RAD_W-1:0] second_radius;
    logic out_valid;
    logic out_stall;
    logic signed [COORD_W-1:0] merged_center_x, merged_center_y, merged_center_z;
    logic [RAD_W-1:0] merged_radius;
    logic [1:0] outcome;

    bsm_res_t expected_spheres[$];
    int mismatches;
    int idle_cycles;
    bit rx_quiet;

    bounding_sphere_merge dut (.*);

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint unsigned isqrt128(logic [127:0] n);
        logic [127:0] r;
        logic [127:0] t;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= n)
                r = t;
        end
        return r[63:0];
    endfunction

    function automatic longint clamp_coord(logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 64'sd2147483647;
        if (v < -128'sd2147483648)
            return -64'sd2147483648;
        return longint'(v);
    endfunction

    function automatic bsm_res_t merge_spheres(longint c1[3], longint c2[3],
                                               longint r1, longint r2);
        bsm_res_t res;
        longint d[3];
        logic [127:0] sum;
        logic [127:0] prod;
        logic [127:0] q;
        longint len, lo, top, hi, s, ms, md, qv;
        logic signed [127:0] v;
        longint cv[3];
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = c2[i] - c1[i];
            md = d[i] < 0 ? -d[i] : d[i];
            sum += 128'(md) * 128'(md);
        end
        len = longint'(isqrt128(sum));
        if (r1 - r2 >= len) begin
            res.cx = c1[0][COORD_W-1:0];
            res.cy = c1[1][COORD_W-1:0];
            res.cz = c1[2][COORD_W-1:0];
            res.radius = r1[RAD_W-1:0];
            res.outcome = OUT_FIRST;
            return res;
        end
        if (r2 - r1 >= len) begin
            res.cx = c2[0][COORD_W-1:0];
            res.cy = c2[1][COORD_W-1:0];
            res.cz = c2[2][COORD_W-1:0];
            res.radius = r2[RAD_W-1:0];
            res.outcome = OUT_SECOND;
            return res;
        end
        lo = (len - r2 < -r1) ? len - r2 : -r1;
        top = (len + r2 > r1) ? len + r2 : r1;
        hi = (top - lo) >>> 1;
        s = hi + lo;
        ms = s < 0 ? -s : s;
        for (int i = 0; i < 3; i++) begin
            md = d[i] < 0 ? -d[i] : d[i];
            prod = 128'(md) * 128'(ms);
            q = prod / 128'(len);
            if (q > (128'd1 << 62))
                q = 128'd1 << 62;
            qv = longint'(q[63:0]);
            if ((d[i] < 0) != (s < 0))
                v = 128'(c1[i]) - 128'(qv);
            else
                v = 128'(c1[i]) + 128'(qv);
            cv[i] = clamp_coord(v);
        end
        res.cx = cv[0][COORD_W-1:0];
        res.cy = cv[1][COORD_W-1:0];
        res.cz = cv[2][COORD_W-1:0];
        res.radius = (hi > longint'(RAD_MAX)) ? RAD_MAX : hi[RAD_W-1:0];
        res.outcome = OUT_MERGED;
        return res;
    endfunction

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                             logic [30:0] ar, logic [31:0] bx, logic [31:0] by,
                             logic [31:0] bz, logic [30:0] br);
        longint c1[3];
        longint c2[3];
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        first_center_x <= ax; first_center_y <= ay; first_center_z <= az;
        first_radius <= ar;
        second_center_x <= bx; second_center_y <= by; second_center_z <= bz;
        second_radius <= br;
        c1[0] = longint'(signed'(ax)); c1[1] = longint'(signed'(ay));
        c1[2] = longint'(signed'(az));
        c2[0] = longint'(signed'(bx)); c2[1] = longint'(signed'(by));
        c2[2] = longint'(signed'(bz));
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_spheres.push_back(merge_spheres(c1, c2, longint'(ar), longint'(br)));
    endtask

    task automatic test_directed();
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(32'h10000, 0, 0, 31'h20000, 32'h10000, 0, 0, 31'h20000);
        send_pair(0, 0, 0, 31'h50000, 32'h10000, 0, 0, 31'h10000);
        send_pair(0, 0, 0, 31'h10000, 32'h10000, 0, 0, 31'h50000);
        send_pair(0, 0, 0, 31'h10000, 32'h40000, 32'h30000, 0, 31'h10000);
        send_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff);
        send_pair(32'h80000000, 32'h80000000, 32'h80000000, 0,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
        send_pair(32'h7fffffff, 0, 0, 31'h7fffffff, 32'h80000000, 0, 0, 0);
        send_pair(32'h80000000, 0, 0, 0, 32'h7fffffff, 0, 0, 31'h7fffffff);
        send_pair(0, 0, 0, 31'h10000, 32'h1, 32'h1, 0, 31'h10000);
        send_pair(0, 0, 0, 31'h3, 32'h1, 32'h1, 32'h1, 31'h2);
        send_pair(0, 0, 0, 31'h7fffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
        send_pair(32'h12345678, 32'hfedcba98, 32'h0, 31'h100,
                  32'hedcba987, 32'h01234567, 32'hffff0000, 31'h7ffff000);
        send_pair(32'h00030000, 32'hfffd0000, 0, 31'h8000,
                  32'hfffd0000, 32'h00030000, 0, 31'h8000);
    endtask

    task automatic test_random_pairs(int count);
        logic [31:0] b[6];
        logic [30:0] ar, br;
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 3);
            for (int i = 0; i < 6; i++) begin
                if (kind == 0)
                    b[i] = $urandom();
                else if (kind == 1)
                    b[i] = $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
                else
                    b[i] = $signed($urandom_range(0, 32'h02000000)) - 32'sh01000000;
            end
            if (kind == 3)
                for (int i = 3; i < 6; i++)
                    b[i] = b[i - 3] + ($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
            if (kind == 0) begin
                ar = 31'($urandom()); br = 31'($urandom());
            end else begin
                ar = 31'($urandom_range(0, 32'h01000000));
                br = 31'($urandom_range(0, 32'h01000000));
            end
            send_pair(b[0], b[1], b[2], ar, b[3], b[4], b[5], br);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (rx_quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 25) ||
                             (out_stall && $urandom_range(0, 99) < 70);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk) begin
        bsm_res_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_spheres.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: %0d %0d %0d r=%0d o=%0d",
                             merged_center_x, merged_center_y, merged_center_z,
                             merged_radius, outcome);
            end else begin
                want = expected_spheres.pop_front();
                if (merged_center_x !== want.cx || merged_center_y !== want.cy ||
                    merged_center_z !== want.cz || merged_radius !== want.radius ||
                    outcome !== want.outcome) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d %0d %0d r=%0d o=%0d, got %0d %0d %0d r=%0d o=%0d",
                                 want.cx, want.cy, want.cz, want.radius, want.outcome,
                                 merged_center_x, merged_center_y, merged_center_z,
                                 merged_radius, outcome);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        rx_quiet = 1'b0;
        in_valid = 1'b0;
        first_center_x = 0; first_center_y = 0; first_center_z = 0; first_radius = 0;
        second_center_x = 0; second_center_y = 0; second_center_z = 0; second_radius = 0;
        mismatches = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_pairs(1200);
        in_valid <= 1'b0;
        rx_quiet = $urandom_range(0, 1);
        while (expected_spheres.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
